[rtl/rffe_pkg.sv]
// Shared types, codes and widths for the RFFE register frame master.
package rffe_pkg;

  // Field widths of one request item and one slot item
  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned RegAddrW  = 5;
  localparam int unsigned DataW     = 8;
  localparam int unsigned SlaveW    = 4;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned HeaderW   = SlaveW + CmdW + RegAddrW;
  localparam int unsigned TxW       = HeaderW + DataW;
  localparam int unsigned CntW      = 4;

  // Configuration port
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  // Register indexes
  localparam logic [0:0] RegSlaveAddr = 1'b0;

  // Reset value of the slave address register
  localparam logic [SlaveW-1:0] SlaveAddrRst = 4'd4;

  // Frame commands
  localparam logic [CmdW-1:0] CmdWrite = 3'b010;
  localparam logic [CmdW-1:0] CmdRead  = 3'b011;

  // Slot counts at which a phase ends
  localparam logic [CntW-1:0] HeaderLast = 4'd12;
  localparam logic [CntW-1:0] ByteLast   = 4'd8;
  localparam logic [CntW-1:0] ReadLast   = 4'd10;

  // Request codes
  typedef enum logic [ReqTypeW-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } rffe_req_e;

  // Frame phases
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_START  = 8'b0000_0010,
    PH_HEADER = 8'b0000_0100,
    PH_HPAR   = 8'b0000_1000,
    PH_WDATA  = 8'b0001_0000,
    PH_WPAR   = 8'b0010_0000,
    PH_PARK   = 8'b0100_0000,
    PH_RDATA  = 8'b1000_0000
  } rffe_phase_e;

  // One bus slot result
  typedef struct packed {
    logic             sdata_level;
    logic             sdata_drive;
    logic             sclk_pulse;
    logic             start_pulse;
    logic [DataW-1:0] read_data;
    logic             read_valid;
    logic             last;
    logic             idle_slot;
  } rffe_slot_t;

endpackage

[rtl/rffe_ifs.sv]
// Valid/ready channel interfaces for request items and bus slot items.
interface rffe_req_if;
  import rffe_pkg::*;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [RegAddrW-1:0] reg_addr;
  logic [DataW-1:0]    write_data;
  logic                sdata_in;

  modport source (output valid, req_type, reg_addr, write_data, sdata_in, input ready);
  modport sink   (input valid, req_type, reg_addr, write_data, sdata_in, output ready);
endinterface

interface rffe_slot_if;
  import rffe_pkg::*;
  logic             valid;
  logic             ready;
  logic             sdata_level;
  logic             sdata_drive;
  logic             sclk_pulse;
  logic             start_pulse;
  logic [DataW-1:0] read_data;
  logic             read_valid;
  logic             last;
  logic             idle_slot;

  modport source (output valid, sdata_level, sdata_drive, sclk_pulse, start_pulse,
                  read_data, read_valid, last, idle_slot, input ready);
  modport sink   (input valid, sdata_level, sdata_drive, sclk_pulse, start_pulse,
                  read_data, read_valid, last, idle_slot, output ready);
endinterface

[rtl/rffe_register_frame_master.sv]
// A tick item's slot item is registered in the output register, or in the skid entry while the output waits.
// Throughput: one item per cycle while ready is high; the frame state is updated in a single pass.
// A two-entry output stage (result register plus skid) lets items enter while
// a slot item waits downstream; ready drops only when both entries are full.
// Reset (rst_ni low, asynchronous): idle phase, slave address 4, output empty.
// A write frame is 24 slots, a read frame 25 slots, plus the loading request.
module rffe_register_frame_master
  import rffe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  rffe_req_if.sink            in_i,
  rffe_slot_if.source         out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // Configuration register
  logic [SlaveW-1:0] slave_q;
  logic              reg_sel;

  // Frame state
  rffe_phase_e       phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TxW-1:0]    tx_q, tx_d;
  logic [DataW-1:0]  rx_q, rx_d;
  logic              is_read_q, is_read_d;
  logic              par_q, par_d;

  // Output stage
  rffe_slot_t        slot;
  rffe_slot_t        out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  logic              in_fire;
  logic              is_req;
  logic              is_tick;
  logic [CntW-1:0]   cnt_inc;
  logic [CmdW-1:0]   cmd;

  // APB access, one register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ApbAddrW-1] == RegSlaveAddr);
  assign prdata  = reg_sel ? {{(ApbDataW-SlaveW){1'b0}}, slave_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= SlaveAddrRst;
    end else if (psel && penable && pwrite && reg_sel) begin
      slave_q <= pwdata[SlaveW-1:0];
    end
  end

  // Input handshake
  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_req     = (in_i.req_type == REQ_WRITE) || (in_i.req_type == REQ_READ);
  assign is_tick    = (in_i.req_type == REQ_TICK);
  assign cnt_inc    = cnt_q + 1'b1;
  assign cmd        = (in_i.req_type == REQ_READ) ? CmdRead : CmdWrite;

  // Load a frame on a request in the idle phase, emit one slot on a tick
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    is_read_d = is_read_q;
    par_d     = par_q;
    slot      = '0;
    slot.sdata_drive = 1'b1;

    if (in_fire && is_req && (phase_q == PH_IDLE)) begin
      is_read_d = (in_i.req_type == REQ_READ);
      tx_d      = {slave_q, cmd, in_i.reg_addr,
                   (in_i.req_type == REQ_WRITE) ? in_i.write_data : {DataW{1'b0}}};
      cnt_d     = '0;
      par_d     = 1'b0;
      rx_d      = '0;
      phase_d   = PH_START;
    end else if (in_fire && is_tick) begin
      case (phase_q)
        PH_START: begin
          slot.start_pulse = 1'b1;
          slot.sdata_level = 1'b1;
          cnt_d   = '0;
          par_d   = 1'b0;
          phase_d = PH_HEADER;
        end
        PH_HEADER, PH_WDATA: begin
          // shift out MSB first and fold it into the parity
          slot.sdata_level = tx_q[TxW-1];
          slot.sclk_pulse  = 1'b1;
          par_d = par_q ^ tx_q[TxW-1];
          tx_d  = {tx_q[TxW-2:0], 1'b0};
          cnt_d = cnt_inc;
          if (phase_q == PH_HEADER && cnt_inc >= HeaderLast) begin
            cnt_d   = '0;
            phase_d = PH_HPAR;
          end else if (phase_q == PH_WDATA && cnt_inc >= ByteLast) begin
            cnt_d   = '0;
            phase_d = PH_WPAR;
          end
        end
        PH_HPAR: begin
          slot.sdata_level = ~par_q;
          slot.sclk_pulse  = 1'b1;
          par_d   = 1'b0;
          cnt_d   = '0;
          phase_d = is_read_q ? PH_PARK : PH_WDATA;
        end
        PH_WPAR: begin
          slot.sdata_level = ~par_q;
          slot.sclk_pulse  = 1'b1;
          par_d   = 1'b0;
          phase_d = PH_PARK;
        end
        PH_PARK: begin
          slot.sclk_pulse = 1'b1;
          cnt_d = '0;
          if (is_read_q) begin
            rx_d    = '0;
            phase_d = PH_RDATA;
          end else begin
            slot.last = 1'b1;
            phase_d   = PH_IDLE;
          end
        end
        PH_RDATA: begin
          // sample eight bits, then clock slave parity and park unchecked
          slot.sdata_drive = 1'b0;
          slot.sclk_pulse  = 1'b1;
          if (cnt_q < ByteLast) begin
            rx_d = {rx_q[DataW-2:0], in_i.sdata_in};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= ReadLast) begin
            slot.last       = 1'b1;
            slot.read_valid = 1'b1;
            slot.read_data  = rx_d;
            cnt_d   = '0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          slot.idle_slot = 1'b1;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      tx_q      <= '0;
      rx_q      <= '0;
      is_read_q <= 1'b0;
      par_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      tx_q      <= tx_d;
      rx_q      <= rx_d;
      is_read_q <= is_read_d;
      par_q     <= par_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_o.ready) begin
      if (in_fire && is_tick) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire && is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_o.ready) begin
      if (in_fire && is_tick) begin
        skid_q <= slot;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_fire && is_tick) begin
      out_q <= slot;
    end
  end

  // Drive the slot channel
  assign out_o.valid       = out_valid_q;
  assign out_o.sdata_level = out_q.sdata_level;
  assign out_o.sdata_drive = out_q.sdata_drive;
  assign out_o.sclk_pulse  = out_q.sclk_pulse;
  assign out_o.start_pulse = out_q.start_pulse;
  assign out_o.read_data   = out_q.read_data;
  assign out_o.read_valid  = out_q.read_valid;
  assign out_o.last        = out_q.last;
  assign out_o.idle_slot   = out_q.idle_slot;

endmodule

[rtl/rffe_checker.sv]
// Port-level checks on the slot channel of the frame master, bound to the frame master module.
module rffe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic sdata_level,
  input logic sdata_drive,
  input logic sclk_pulse,
  input logic start_pulse,
  input logic read_valid,
  input logic last,
  input logic idle_slot
);

  // A waiting slot item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("slot item withdrawn before it was taken");

  // A returned read byte closes the frame
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && read_valid |-> last && !sdata_drive && !idle_slot)
    else $error("read byte outside the final read slot");

  // Idle slots hold the line low with no clock
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && idle_slot |-> sdata_drive && !sdata_level && !sclk_pulse && !start_pulse
      && !last)
    else $error("idle slot shows bus activity");

  // The start slot pulses data while the clock stays low
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && start_pulse |-> sdata_level && sdata_drive && !sclk_pulse && !last)
    else $error("malformed start slot");

  // A released line is always clocked and reads low
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !sdata_drive |-> sclk_pulse && !sdata_level)
    else $error("released line slot without clock");

endmodule

bind rffe_register_frame_master rffe_checker u_rffe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .sdata_level (out_o.sdata_level),
  .sdata_drive (out_o.sdata_drive),
  .sclk_pulse  (out_o.sclk_pulse),
  .start_pulse (out_o.start_pulse),
  .read_valid  (out_o.read_valid),
  .last        (out_o.last),
  .idle_slot   (out_o.idle_slot)
);

[sim/tb.sv]
// Self-checking testbench for the RFFE register frame master: directed and random frames.
`timescale 1ns / 1ps

module tb;
  import rffe_pkg::*;

  localparam int unsigned IdlePct  = 27;
  localparam int unsigned DrainMax = 2000;
  localparam longint      LimitNs  = 64'd5_000_000;

  logic clk;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  rffe_req_if  req_if ();
  rffe_slot_if slot_if ();

  rffe_register_frame_master dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (req_if),
    .out_o   (slot_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Frame state mirrored from the accepted request and tick items
  rffe_phase_e       fm_phase;
  logic [4:0]        fm_cnt;
  logic [21:0]       fm_tx;
  logic [DataW-1:0]  fm_rx;
  logic              fm_read;
  logic              fm_par;
  logic [SlaveW-1:0] fm_slave;

  rffe_slot_t  expected_slots[$];
  rffe_slot_t  exp_slot;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned slots_seen;
  bit          steady;

  // Clock and watchdog
  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(LimitNs);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("MISMATCH slot %0d %s: expected %0h got %0h", slots_seen, what, exp_v, got_v);
    error_count++;
  endtask

  // Shift the next header or data bit out and fold it into the parity
  function automatic logic shift_tx_bit();
    logic b;
    b = fm_tx[21];
    fm_par = fm_par ^ b;
    fm_tx = {fm_tx[20:0], 1'b0};
    fm_cnt = fm_cnt + 5'd1;
    return b;
  endfunction

  // Advance the mirrored frame by one item and queue the slot it causes
  task automatic advance_frame(input rffe_req_e req, input logic [RegAddrW-1:0] addr,
                               input logic [DataW-1:0] wdat, input logic sin);
    rffe_slot_t s;
    s = '0;
    s.sdata_drive = 1'b1;
    if (req == REQ_WRITE || req == REQ_READ) begin
      if (fm_phase == PH_IDLE) begin
        fm_read = (req == REQ_READ);
        fm_tx = {fm_slave, (req == REQ_READ) ? CmdRead : CmdWrite, addr,
                 (req == REQ_WRITE) ? wdat : 8'h00, 2'b00};
        fm_cnt = '0;
        fm_par = 1'b0;
        fm_rx = '0;
        fm_phase = PH_START;
      end
    end else if (req == REQ_TICK) begin
      case (fm_phase)
        PH_START: begin
          s.start_pulse = 1'b1;
          s.sdata_level = 1'b1;
          fm_cnt = '0;
          fm_par = 1'b0;
          fm_phase = PH_HEADER;
        end
        PH_HEADER: begin
          s.sdata_level = shift_tx_bit();
          s.sclk_pulse = 1'b1;
          if (fm_cnt >= HeaderLast) begin
            fm_cnt = '0;
            fm_phase = PH_HPAR;
          end
        end
        PH_HPAR: begin
          s.sdata_level = ~fm_par;
          s.sclk_pulse = 1'b1;
          fm_par = 1'b0;
          fm_cnt = '0;
          fm_phase = fm_read ? PH_PARK : PH_WDATA;
        end
        PH_WDATA: begin
          s.sdata_level = shift_tx_bit();
          s.sclk_pulse = 1'b1;
          if (fm_cnt >= ByteLast) begin
            fm_cnt = '0;
            fm_phase = PH_WPAR;
          end
        end
        PH_WPAR: begin
          s.sdata_level = ~fm_par;
          s.sclk_pulse = 1'b1;
          fm_par = 1'b0;
          fm_phase = PH_PARK;
        end
        PH_PARK: begin
          s.sclk_pulse = 1'b1;
          fm_cnt = '0;
          if (fm_read) begin
            fm_rx = '0;
            fm_phase = PH_RDATA;
          end else begin
            s.last = 1'b1;
            fm_phase = PH_IDLE;
          end
        end
        PH_RDATA: begin
          s.sdata_drive = 1'b0;
          s.sclk_pulse = 1'b1;
          if (fm_cnt < ByteLast) fm_rx = {fm_rx[DataW-2:0], sin};
          fm_cnt = fm_cnt + 5'd1;
          if (fm_cnt >= ReadLast) begin
            s.last = 1'b1;
            s.read_valid = 1'b1;
            s.read_data = fm_rx;
            fm_cnt = '0;
            fm_phase = PH_IDLE;
          end
        end
        default: s.idle_slot = 1'b1;
      endcase
      expected_slots.push_back(s);
    end
  endtask

  // Predict on accepted requests, check accepted slots against the oldest prediction
  always @(posedge clk) begin
    if (req_if.valid && req_if.ready) begin
      advance_frame(rffe_req_e'(req_if.req_type), req_if.reg_addr, req_if.write_data,
                    req_if.sdata_in);
    end
    if (slot_if.valid && slot_if.ready) begin
      if (expected_slots.size() == 0) begin
        report_mismatch("slot with none expected", 0, 0);
      end else begin
        exp_slot = expected_slots.pop_front();
        if (slot_if.sdata_level !== exp_slot.sdata_level)
          report_mismatch("sdata_level", exp_slot.sdata_level, slot_if.sdata_level);
        if (slot_if.sdata_drive !== exp_slot.sdata_drive)
          report_mismatch("sdata_drive", exp_slot.sdata_drive, slot_if.sdata_drive);
        if (slot_if.sclk_pulse !== exp_slot.sclk_pulse)
          report_mismatch("sclk_pulse", exp_slot.sclk_pulse, slot_if.sclk_pulse);
        if (slot_if.start_pulse !== exp_slot.start_pulse)
          report_mismatch("start_pulse", exp_slot.start_pulse, slot_if.start_pulse);
        if (slot_if.read_data !== exp_slot.read_data)
          report_mismatch("read_data", exp_slot.read_data, slot_if.read_data);
        if (slot_if.read_valid !== exp_slot.read_valid)
          report_mismatch("read_valid", exp_slot.read_valid, slot_if.read_valid);
        if (slot_if.last !== exp_slot.last)
          report_mismatch("last", exp_slot.last, slot_if.last);
        if (slot_if.idle_slot !== exp_slot.idle_slot)
          report_mismatch("idle_slot", exp_slot.idle_slot, slot_if.idle_slot);
      end
      slots_seen++;
    end
  end

  // Stall the slot receiver at random
  always @(negedge clk) begin
    slot_if.ready = steady ? 1'b1 : !chance(IdlePct);
  end

  // Send one item; hold it until accepted
  task automatic send_item(input rffe_req_e req, input logic [RegAddrW-1:0] addr,
                           input logic [DataW-1:0] wdat, input logic sin);
    @(negedge clk);
    while (!steady && chance(IdlePct)) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.req_type   = req;
    req_if.reg_addr   = addr;
    req_if.write_data = wdat;
    req_if.sdata_in   = sin;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    // let the predictor take the item before the caller looks at the frame state
    #1;
  endtask

  task automatic send_tick(input logic sin);
    send_item(REQ_TICK, RegAddrW'($urandom_range(0, 31)), DataW'($urandom_range(0, 255)), sin);
  endtask

  // Load a frame and tick it to its end; optionally mix in random items, whose requests are dropped
  task automatic run_frame(input rffe_req_e req, input logic [RegAddrW-1:0] addr,
                           input logic [DataW-1:0] wdat, input logic [7:0] sin_bits,
                           input bit noisy);
    int unsigned n;
    n = 0;
    send_item(req, addr, wdat, 1'($urandom_range(0, 1)));
    while (fm_phase != PH_IDLE) begin
      if (noisy && chance(4)) begin
        send_item(rffe_req_e'($urandom_range(0, 3)), RegAddrW'($urandom_range(0, 31)),
                  DataW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_tick(sin_bits[7 - (n % 8)]);
        n++;
      end
    end
  endtask

  // Drop valid and wait for every predicted slot, then let the block settle
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_slots.size() != 0 && guard < DrainMax) begin
      @(posedge clk);
      guard++;
    end
    if (expected_slots.size() != 0)
      report_mismatch("slots never arrived", expected_slots.size(), 0);
    expected_slots.delete();
    repeat (4) @(posedge clk);
  endtask

  // Close any open frame, then write the slave address and read it back
  task automatic set_slave_address(input logic [SlaveW-1:0] value);
    while (fm_phase != PH_IDLE) send_tick(1'($urandom_range(0, 1)));
    wait_drained();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {RegSlaveAddr, 2'b00};
    pwdata  = ApbDataW'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    fm_slave = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== ApbDataW'(value)) report_mismatch("slave_address readback", value, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Idle ticks after reset, with the unused request code mixed in
  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_item(REQ_NONE, 5'd31, 8'hFF, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
  endtask

  // Write frames at the field extremes, plus one with a mixed address and data pattern
  task automatic test_write_frames();
    run_frame(REQ_WRITE, 5'd31, 8'hFF, 8'h00, 1'b0);
    run_frame(REQ_WRITE, 5'd0, 8'h00, 8'hFF, 1'b0);
    run_frame(REQ_WRITE, 5'd21, 8'hA5, 8'h5A, 1'b0);
    wait_drained();
  endtask

  // Read frames with all-ones, all-zeros and alternating line samples
  task automatic test_read_frames();
    run_frame(REQ_READ, 5'd0, 8'h00, 8'hFF, 1'b0);
    run_frame(REQ_READ, 5'd31, 8'hFF, 8'h00, 1'b0);
    run_frame(REQ_READ, 5'd10, 8'h3C, 8'hAA, 1'b0);
    wait_drained();
  endtask

  // Requests and the unused code arriving while a frame is loaded or running
  task automatic test_busy_requests();
    send_item(REQ_WRITE, 5'd7, 8'h81, 1'b0);
    send_item(REQ_READ, 5'd30, 8'h00, 1'b1);
    repeat (5) send_tick(1'($urandom_range(0, 1)));
    send_item(REQ_READ, 5'd1, 8'h00, 1'b1);
    send_item(REQ_WRITE, 5'd2, 8'h7E, 1'b0);
    send_item(REQ_NONE, 5'd3, 8'h00, 1'b1);
    while (fm_phase != PH_IDLE) send_tick(1'($urandom_range(0, 1)));
    send_tick(1'b0);
    wait_drained();
  endtask

  // Slave address extremes carried into write and read frames
  task automatic test_slave_address();
    set_slave_address(4'd15);
    run_frame(REQ_WRITE, 5'd16, 8'h01, 8'h00, 1'b0);
    set_slave_address(4'd0);
    run_frame(REQ_READ, 5'd15, 8'h80, 8'h96, 1'b0);
    set_slave_address(SlaveW'($urandom_range(0, 15)));
    run_frame(REQ_WRITE, 5'd5, 8'h55, 8'h00, 1'b0);
    wait_drained();
  endtask

  // Mostly complete frames with random content, some cut short, some noise
  task automatic test_random_traffic(input int unsigned count, input bit no_gaps);
    int unsigned target;
    int unsigned roll;
    int unsigned k;
    target = items_sent + count;
    steady = no_gaps;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        run_frame(rffe_req_e'($urandom_range(0, 1)), RegAddrW'($urandom_range(0, 31)),
                  DataW'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), chance(20));
        k = $urandom_range(0, 2);
        repeat (k) send_tick(1'($urandom_range(0, 1)));
      end else if (roll < 90) begin
        send_item(rffe_req_e'($urandom_range(0, 1)), RegAddrW'($urandom_range(0, 31)),
                  DataW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        k = $urandom_range(0, 24);
        repeat (k) send_tick(1'($urandom_range(0, 1)));
      end else begin
        send_item(rffe_req_e'($urandom_range(0, 3)), RegAddrW'($urandom_range(0, 31)),
                  DataW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_TICK;
    req_if.reg_addr   = '0;
    req_if.write_data = '0;
    req_if.sdata_in   = 1'b0;
    slot_if.ready     = 1'b1;
    fm_phase          = PH_IDLE;
    fm_cnt            = '0;
    fm_tx             = '0;
    fm_rx             = '0;
    fm_read           = 1'b0;
    fm_par            = 1'b0;
    fm_slave          = SlaveAddrRst;
    error_count       = 0;
    items_sent        = 0;
    slots_seen        = 0;
    steady            = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_ticks();
    test_write_frames();
    test_read_frames();
    test_busy_requests();
    test_slave_address();

    set_slave_address(4'd0);
    test_random_traffic(300, 1'b0);
    set_slave_address(4'd15);
    test_random_traffic(300, 1'b0);
    set_slave_address(SlaveW'($urandom_range(0, 15)));
    test_random_traffic(450, 1'b1);
    set_slave_address(SlaveW'($urandom_range(0, 15)));
    test_random_traffic(300, 1'b0);

    while (fm_phase != PH_IDLE) send_tick(1'($urandom_range(0, 1)));
    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
